### hdl/jtms_pkg.sv
// Shared package for the Johnson two-machine sequencer.
// Holds field widths, defaults, the controller state type and the
// command and status bundles that link the controller and the datapath.
`default_nettype none

package jtms_pkg;

    localparam int TIME_W        = 16;
    localparam int NUM_W         = 7;
    localparam int SPAN_W        = 23;
    localparam int MAX_JOBS_DEF  = 64;
    localparam int TIME_BITS_DEF = 16;
    localparam int S_DATA_W      = 32;
    localparam int M_DATA_W      = 64;
    localparam int OUT_PAD_W     = M_DATA_W - NUM_W - 2 * TIME_W - SPAN_W;

    localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS_START,
        ST_LOAD_CUR,
        ST_CMP,
        ST_PASS_END,
        ST_EMIT_RD,
        ST_EMIT_A,
        ST_EMIT_B
    } state_t;

    typedef struct packed {
        logic take;
        logic rd_first;
        logic load_cur;
        logic cmp_step;
        logic pass_end;
        logic emit_rd;
        logic emit_a;
        logic emit_out;
    } cmd_t;

    typedef struct packed {
        logic final_in;
        logic lim_zero;
        logic last_cmp;
        logic emit_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

### hdl/jtms_ctrl.sv
// Controller state machine of the Johnson two-machine sequencer.
// Depends on jtms_pkg for the state type and the command and status bundles.
`default_nettype none

module jtms_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire jtms_pkg::status_t status,
    output jtms_pkg::cmd_t         cmd
);
    import jtms_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.take = 1'b1;
                if (status.final_in)
                begin
                    state_next = ST_PASS_START;
                end
            end
            ST_PASS_START:
            begin
                if (status.lim_zero)
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = ST_LOAD_CUR;
                end
            end
            ST_LOAD_CUR:
            begin
                cmd.load_cur = 1'b1;
                state_next   = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp_step = 1'b1;
                if (status.last_cmp)
                begin
                    state_next = ST_PASS_END;
                end
            end
            ST_PASS_END:
            begin
                cmd.pass_end = 1'b1;
                state_next   = ST_PASS_START;
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_A;
            end
            ST_EMIT_A:
            begin
                cmd.emit_a = 1'b1;
                state_next = ST_EMIT_B;
            end
            ST_EMIT_B:
            begin
                if (status.out_free)
                begin
                    cmd.emit_out = 1'b1;
                    state_next   = status.emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/jtms_datapath.sv
// Datapath of the Johnson two-machine sequencer: job memory, bubble-pass
// carry register, makespan accumulators and the output register.
// Depends on jtms_pkg and is driven by jtms_ctrl through cmd_t and status_t.
`default_nettype none

module jtms_datapath #(
    parameter int MAX_JOBS  = jtms_pkg::MAX_JOBS_DEF,
    parameter int TIME_BITS = jtms_pkg::TIME_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire jtms_pkg::cmd_t                cmd,
    output jtms_pkg::status_t                  status,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [jtms_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [jtms_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import jtms_pkg::*;

    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int ADDR_W   = $clog2(MAX_JOBS);
    localparam int STORE_TB = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
    localparam int ENT_W    = CNT_W + 2 * STORE_TB;

    function automatic logic pair_swap(
        input logic [TIME_W-1:0] v0,
        input logic [TIME_W-1:0] v1,
        input logic [TIME_W-1:0] v2,
        input logic [TIME_W-1:0] v3
    );
        logic [1:0]        best_lo;
        logic [1:0]        best_hi;
        logic [TIME_W-1:0] min_lo;
        logic [TIME_W-1:0] min_hi;
        logic [1:0]        best;
        best_lo = (v1 < v0) ? 2'd1 : 2'd0;
        min_lo  = (v1 < v0) ? v1 : v0;
        best_hi = (v3 < v2) ? 2'd3 : 2'd2;
        min_hi  = (v3 < v2) ? v3 : v2;
        best    = (min_hi < min_lo) ? best_hi : best_lo;
        return best[0];
    endfunction

    logic [ENT_W-1:0]  mem [MAX_JOBS];
    logic [ENT_W-1:0]  rdata_reg;
    logic [ENT_W-1:0]  cur_reg;
    logic [ENT_W-1:0]  ent_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              dropped_reg;
    logic [ADDR_W-1:0] lim_reg;
    logic [ADDR_W-1:0] j_reg;
    logic [ADDR_W-1:0] k_reg;
    logic [SPAN_W-1:0] fa_reg;
    logic [SPAN_W-1:0] fb_reg;
    logic              out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic              out_user_reg;
    logic              out_last_reg;

    logic              accept;
    logic              full;
    logic              swap;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ENT_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
    logic [TIME_W-1:0] in_ta;
    logic [TIME_W-1:0] in_tb;
    logic [TIME_W-1:0] cur_ta;
    logic [TIME_W-1:0] cur_tb;
    logic [TIME_W-1:0] nxt_ta;
    logic [TIME_W-1:0] nxt_tb;
    logic [TIME_W-1:0] ent_ta;
    logic [TIME_W-1:0] ent_tb;
    logic [TIME_W-1:0] rd_ta;
    logic [CNT_W+NUM_W-1:0] ent_num_wide;
    logic [SPAN_W:0]   fa_sum;
    logic [SPAN_W:0]   fb_sum;
    logic [SPAN_W-1:0] fb_base;
    logic [SPAN_W-1:0] fa_next;
    logic [SPAN_W-1:0] fb_next;

    assign in_ta  = s_tdata[TIME_W-1:0];
    assign in_tb  = s_tdata[2*TIME_W-1:TIME_W];
    assign cur_ta = TIME_W'(cur_reg[STORE_TB-1:0]);
    assign cur_tb = TIME_W'(cur_reg[2*STORE_TB-1:STORE_TB]);
    assign nxt_ta = TIME_W'(rdata_reg[STORE_TB-1:0]);
    assign nxt_tb = TIME_W'(rdata_reg[2*STORE_TB-1:STORE_TB]);
    assign rd_ta  = nxt_ta;
    assign ent_ta = TIME_W'(ent_reg[STORE_TB-1:0]);
    assign ent_tb = TIME_W'(ent_reg[2*STORE_TB-1:STORE_TB]);
    assign ent_num_wide = {{NUM_W{1'b0}}, ent_reg[ENT_W-1:2*STORE_TB]};

    assign s_tready = cmd.take;
    assign accept   = cmd.take && s_tvalid;
    assign full     = (count_reg == CNT_W'(MAX_JOBS));
    assign swap     = pair_swap(cur_ta, nxt_ta, nxt_tb, cur_tb);

    assign fa_sum  = {1'b0, fa_reg} + (SPAN_W + 1)'(rd_ta);
    assign fa_next = fa_sum[SPAN_W] ? SPAN_MAX : fa_sum[SPAN_W-1:0];
    assign fb_base = (fa_reg > fb_reg) ? fa_reg : fb_reg;
    assign fb_sum  = {1'b0, fb_base} + (SPAN_W + 1)'(ent_tb);
    assign fb_next = fb_sum[SPAN_W] ? SPAN_MAX : fb_sum[SPAN_W-1:0];

    assign status.final_in  = accept && s_tlast;
    assign status.lim_zero  = (lim_reg == '0);
    assign status.last_cmp  = (ADDR_W'(j_reg + ADDR_W'(1)) == lim_reg);
    assign status.emit_last = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
    assign status.out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        if (cmd.rd_first)
        begin
            raddr = '0;
        end
        else if (cmd.load_cur)
        begin
            raddr = ADDR_W'(1);
        end
        else if (cmd.emit_rd)
        begin
            raddr = k_reg;
        end
        else
        begin
            raddr = ADDR_W'(j_reg + ADDR_W'(2));
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = j_reg;
        wdata = cur_reg;
        if (accept && !full)
        begin
            we    = 1'b1;
            waddr = count_reg[ADDR_W-1:0];
            wdata = {CNT_W'(count_reg + CNT_W'(1)), in_tb[STORE_TB-1:0], in_ta[STORE_TB-1:0]};
        end
        else if (cmd.cmp_step)
        begin
            we    = 1'b1;
            waddr = j_reg;
            wdata = swap ? rdata_reg : cur_reg;
        end
        else if (cmd.pass_end)
        begin
            we    = 1'b1;
            waddr = lim_reg;
            wdata = cur_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_cur)
        begin
            cur_reg <= rdata_reg;
        end
        else if (cmd.cmp_step && !swap)
        begin
            cur_reg <= rdata_reg;
        end
        if (cmd.emit_a)
        begin
            ent_reg <= rdata_reg;
        end
        if (cmd.emit_out)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}},
                             status.emit_last ? fb_next : {SPAN_W{1'b0}},
                             ent_tb, ent_ta, ent_num_wide[NUM_W-1:0]};
            out_user_reg <= dropped_reg;
            out_last_reg <= status.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            lim_reg       <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            fa_reg        <= '0;
            fb_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (full)
                begin
                    dropped_reg <= 1'b1;
                    lim_reg     <= ADDR_W'(MAX_JOBS - 1);
                end
                else
                begin
                    count_reg <= CNT_W'(count_reg + CNT_W'(1));
                    lim_reg   <= count_reg[ADDR_W-1:0];
                end
            end
            if (cmd.rd_first)
            begin
                j_reg <= '0;
            end
            if (cmd.cmp_step)
            begin
                j_reg <= ADDR_W'(j_reg + ADDR_W'(1));
            end
            if (cmd.pass_end)
            begin
                lim_reg <= ADDR_W'(lim_reg - ADDR_W'(1));
            end
            if (cmd.emit_a)
            begin
                fa_reg <= fa_next;
            end
            if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.emit_out)
            begin
                out_valid_reg <= 1'b1;
                fb_reg        <= fb_next;
                k_reg         <= ADDR_W'(k_reg + ADDR_W'(1));
                if (status.emit_last)
                begin
                    count_reg   <= '0;
                    dropped_reg <= 1'b0;
                    fa_reg      <= '0;
                    fb_reg      <= '0;
                    k_reg       <= '0;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

### hdl/johnson_two_machine_sequencer_top.sv
// Top level of the Johnson two-machine flow-shop sequencer.
// Depends on jtms_pkg, jtms_ctrl and jtms_datapath.
//
// Usage: each input word on the s_ group is one job; s_tdata holds the time on
// machine A in the low half and the time on machine B in the high half, and
// s_tlast marks the last job of a set. Jobs are taken one per cycle while
// loading. Jobs that find the store full are dropped and the set is flagged.
// After the last job the block sorts the set by Johnson's rule with a bubble
// sort over the job memory, one pair compared per cycle, and s_tready is low
// meanwhile. The memory's single read and single write port set this pace.
// It then emits one word per job in schedule order on the m_ group: it reads
// the job, adds its machine-A time, then registers the word before it reads
// the next job; m_tlast marks the last word, which also carries the
// makespan, and m_tuser flags a set that dropped jobs. An output register holds
// the pending word, so a stalled receiver only holds emission in place, and
// loading of the next set starts while the final word still waits.
// Reset empties the set and returns the block to loading.
`default_nettype none

module johnson_two_machine_sequencer_top #(
    parameter int MAX_JOBS  = jtms_pkg::MAX_JOBS_DEF,
    parameter int TIME_BITS = jtms_pkg::TIME_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // time_on_first [15:0], time_on_second [31:16]
    input  wire logic [jtms_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // job_number [6:0], out_time_first [22:7], out_time_second [38:23],
    // makespan [61:39], zero fill [63:62]
    output logic [jtms_pkg::M_DATA_W-1:0]      m_tdata,
    // overflow [0]
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import jtms_pkg::*;

    cmd_t    cmd;
    status_t status;

    jtms_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    jtms_datapath #(
        .MAX_JOBS  (MAX_JOBS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### tb/sv/schedule_checker.sv
// Scoreboard for the Johnson two-machine sequencer: watches both stream ports,
// predicts each emitted schedule word and compares it field by field.
// Depends on jtms_pkg for the port widths and the default store size.
`timescale 1ns / 1ps

module schedule_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [jtms_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [jtms_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          m_tuser,
    input  logic                          m_tlast,
    output int                            errors,
    output int                            pending
);

    localparam int CAP       = jtms_pkg::MAX_JOBS_DEF;
    localparam int TW        = jtms_pkg::TIME_W;
    localparam int NW        = jtms_pkg::NUM_W;
    localparam int SW        = jtms_pkg::SPAN_W;
    localparam int PAIR_KEYS = 4;
    localparam int TA_LSB    = NW;
    localparam int TB_LSB    = NW + TW;
    localparam int SPAN_LSB  = NW + 2 * TW;
    localparam int PAD_LSB   = SPAN_LSB + SW;
    localparam longint SPAN_LIMIT = (longint'(1) << SW) - 1;

    typedef struct packed {
        logic [NW-1:0] num;
        logic [TW-1:0] ta;
        logic [TW-1:0] tb;
    } job_t;

    typedef struct packed {
        logic [NW-1:0] num;
        logic [TW-1:0] ta;
        logic [TW-1:0] tb;
        logic [SW-1:0] span;
        logic          dropped;
        logic          last;
    } sched_word_t;

    job_t        held_jobs [CAP];
    int          held_count  = 0;
    logic        set_dropped = 1'b0;
    sched_word_t schedule_due [$];
    int          fail_count  = 0;
    int          due_count   = 0;
    int          words_seen  = 0;

    assign errors  = fail_count;
    assign pending = due_count;

    function automatic logic johnson_swap(job_t p, job_t q);
        logic [TW-1:0] v [PAIR_KEYS];
        int            best;
        v[0] = p.ta;
        v[1] = q.ta;
        v[2] = q.tb;
        v[3] = p.tb;
        best = 0;
        for (int k = 1; k < PAIR_KEYS; k++)
            if (v[k] < v[best])
                best = k;
        return best[0];
    endfunction

    task automatic sequence_set();
        job_t        tmp;
        longint      fin_a;
        longint      fin_b;
        sched_word_t w;
        for (int i = 0; i < held_count; i++)
            for (int j = 0; j + 1 + i < held_count; j++)
                if (johnson_swap(held_jobs[j], held_jobs[j + 1]))
                begin
                    tmp              = held_jobs[j];
                    held_jobs[j]     = held_jobs[j + 1];
                    held_jobs[j + 1] = tmp;
                end
        fin_a = 0;
        fin_b = 0;
        for (int k = 0; k < held_count; k++)
        begin
            fin_a += held_jobs[k].ta;
            if (fin_a > SPAN_LIMIT)
                fin_a = SPAN_LIMIT;
            if (fin_a > fin_b)
                fin_b = fin_a;
            fin_b += held_jobs[k].tb;
            if (fin_b > SPAN_LIMIT)
                fin_b = SPAN_LIMIT;
            w.num     = held_jobs[k].num;
            w.ta      = held_jobs[k].ta;
            w.tb      = held_jobs[k].tb;
            w.last    = (k == held_count - 1);
            w.span    = w.last ? fin_b[SW-1:0] : '0;
            w.dropped = set_dropped;
            schedule_due.insert(schedule_due.size(), w);
        end
        held_count  = 0;
        set_dropped = 1'b0;
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("ERROR: output word %0d, %s: got 0x%0h, expected 0x%0h",
                 words_seen, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin : watch
        sched_word_t due;
        if (!rst_n)
        begin
            held_count  = 0;
            set_dropped = 1'b0;
            schedule_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (schedule_due.size() == 0)
                    report_mismatch("word with none expected, job_number", m_tdata[NW-1:0], 0);
                else
                begin
                    due = schedule_due.pop_front();
                    if (m_tdata[NW-1:0] !== due.num)
                        report_mismatch("job_number", m_tdata[NW-1:0], due.num);
                    if (m_tdata[TA_LSB +: TW] !== due.ta)
                        report_mismatch("out_time_first", m_tdata[TA_LSB +: TW], due.ta);
                    if (m_tdata[TB_LSB +: TW] !== due.tb)
                        report_mismatch("out_time_second", m_tdata[TB_LSB +: TW], due.tb);
                    if (m_tdata[SPAN_LSB +: SW] !== due.span)
                        report_mismatch("makespan", m_tdata[SPAN_LSB +: SW], due.span);
                    if (m_tdata[jtms_pkg::M_DATA_W-1:PAD_LSB] !== '0)
                        report_mismatch("zero fill", m_tdata[jtms_pkg::M_DATA_W-1:PAD_LSB], 0);
                    if (m_tuser !== due.dropped)
                        report_mismatch("overflow", m_tuser, due.dropped);
                    if (m_tlast !== due.last)
                        report_mismatch("last_out", m_tlast, due.last);
                end
                words_seen++;
            end
            if (s_tvalid && s_tready)
            begin
                if (held_count < CAP)
                begin
                    held_jobs[held_count].ta  = s_tdata[TW-1:0];
                    held_jobs[held_count].tb  = s_tdata[2*TW-1:TW];
                    held_jobs[held_count].num = NW'(held_count + 1);
                    held_count++;
                end
                else
                    set_dropped = 1'b1;
                if (s_tlast)
                    sequence_set();
            end
        end
        due_count <= schedule_due.size();
    end

endmodule

### tb/sv/testbench.sv
// Top of the Johnson two-machine sequencer testbench: clock, reset, job stimulus
// with random gaps, receiver stalls, a watchdog and the final verdict.
// Depends on jtms_pkg, johnson_two_machine_sequencer_top and schedule_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int CAP            = jtms_pkg::MAX_JOBS_DEF;
    localparam int RANDOM_ITEMS   = 345;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 50;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [jtms_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [jtms_pkg::M_DATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;
    int                            errors;
    int                            pending;

    logic send_idle_on = 1'b0;
    logic take_idle_on = 1'b1;
    int   take_wait    = 0;
    int   quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    johnson_two_machine_sequencer_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    schedule_checker sched_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (m_tlast)
                take_idle_on = ($urandom_range(0, 3) != 0);
            take_wait = take_idle_on ? $urandom_range(0, 10) : 0;
        end
        else if (take_wait > 0)
            take_wait--;
        m_tready <= rst_n && (take_wait == 0);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("johnson_two_machine_sequencer_top: mismatch");
            $finish;
        end
    end

    function automatic logic [15:0] pick_time();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 7));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic push_job(input logic [15:0] a, input logic [15:0] b, input logic last);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_job_set(input int n);
        send_idle_on = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < n; i++)
            push_job(pick_time(), pick_time(), i == n - 1);
    endtask

    initial
    begin : stimulus
        int total;
        int set_no;
        int n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Single-job sets at both extremes, then small sets with forced swaps and ties.
        push_job(16'h0000, 16'h0000, 1'b1);
        push_job(16'hFFFF, 16'hFFFF, 1'b1);
        push_job(16'hFFFF, 16'h0000, 1'b0);
        push_job(16'h0000, 16'hFFFF, 1'b1);
        send_idle_on = 1'b1;
        push_job(16'h0005, 16'h0005, 1'b0);
        push_job(16'h0005, 16'h0005, 1'b0);
        push_job(16'h0005, 16'h0005, 1'b1);
        push_job(16'h0001, 16'h0009, 1'b0);
        push_job(16'h0009, 16'h0001, 1'b0);
        push_job(16'h0003, 16'h0003, 1'b0);
        push_job(16'h0000, 16'hFFFF, 1'b1);
        push_job(16'hAAAA, 16'h5555, 1'b0);
        push_job(16'h5555, 16'hAAAA, 1'b0);
        push_job(16'h8000, 16'h0001, 1'b0);
        push_job(16'h0001, 16'h8000, 1'b0);
        push_job(16'h7FFF, 16'h7FFF, 1'b0);
        push_job(16'h0000, 16'h0000, 1'b1);
        send_idle_on = 1'b0;
        for (int i = 0; i < 8; i++)
            push_job(16'hFFFF, 16'hFFFF, i == 7);

        // Random sets: one that drops its final job, one exactly full, one that drops
        // several jobs, otherwise mostly short sets.
        total  = 0;
        set_no = 0;
        while (total < RANDOM_ITEMS)
        begin
            if (set_no == 0)
                n = CAP + 1;
            else if (set_no == 2)
                n = CAP;
            else if (set_no == 5)
                n = CAP + 4;
            else if ($urandom_range(0, 15) == 0)
                n = $urandom_range(13, 40);
            else
                n = $urandom_range(1, 12);
            send_job_set(n);
            total += n;
            set_no++;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("johnson_two_machine_sequencer_top: match");
        else
            $display("johnson_two_machine_sequencer_top: mismatch");
        $finish;
    end

endmodule
